@@ rtl/nfb_pkg.sv @@
package nfb_pkg;

  localparam int MAX_INPUTS      = 64;
  localparam int ACT_TABLE_DEPTH = 256;
  localparam int WADDR_W         = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int ACT_IDX_W       = $clog2(ACT_TABLE_DEPTH);

  // item queue between front and back
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  localparam logic [2:0] OP_FWD  = 3'd0;
  localparam logic [2:0] OP_OUTG = 3'd1;
  localparam logic [2:0] OP_HID  = 3'd2;
  localparam logic [2:0] OP_WUPD = 3'd3;
  localparam logic [2:0] OP_BUPD = 3'd4;
  localparam logic [2:0] OP_LDW  = 3'd5;
  localparam logic [2:0] OP_LDB  = 3'd6;

  localparam logic [1:0] MODE_SIGMOID = 2'd0;
  localparam logic [1:0] MODE_RELU    = 2'd1;
  localparam logic [1:0] MODE_TANH    = 2'd2;

  localparam logic [1:0] CFG_RATE = 2'd0;
  localparam logic [1:0] CFG_MODE = 2'd1;
  localparam logic [1:0] CFG_OLM  = 2'd2;

  localparam logic [15:0] RATE_RESET = 16'd655;

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint SUM_MAX = (64'sd1 <<< 39) - 64'sd1;
  localparam longint SUM_MIN = -(64'sd1 <<< 39);

  typedef struct packed {
    logic [2:0]          op;
    logic signed [15:0]  value;
    logic signed [15:0]  next_gradient;
    logic [WADDR_W-1:0]  idx;
    logic                inrange;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [15:0] learning_rate;
    logic [1:0]  activation_mode;
    logic        output_layer_mode;
  } cfg_t;

  typedef struct packed {
    logic               clip;
    logic signed [15:0] val;
  } sat16_t;

  typedef logic signed [15:0] act_table_t [ACT_TABLE_DEPTH];

  function automatic sat16_t sat16(input logic signed [63:0] v);
    sat16_t r;
    r.clip = 1'b1;
    if (v > 64'sd32767) begin
      r.val = 16'sh7fff;
    end else if (v < -64'sd32768) begin
      r.val = 16'sh8000;
    end else begin
      r.clip = 1'b0;
      r.val  = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v;
    if (v > SUM_MAX) r = SUM_MAX;
    else if (v < SUM_MIN) r = SUM_MIN;
    return r[39:0];
  endfunction

  // round half up, then floor
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                  input int unsigned k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  // e^(-t/4096) in Q30, elaboration only
  function automatic longint unsigned exp_neg(input longint unsigned t);
    longint unsigned u, u2, u3, u4, u5, r;
    u  = t << 12;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    u4 = (u3 * u) >> 30;
    u5 = (u4 * u) >> 30;
    r  = Q30_ONE + (u2 >> 1) + u4 / 24 - u - u3 / 6 - u5 / 120;
    for (int i = 0; i < 6; i++) r = (r * r + (Q30_ONE >> 1)) >> 30;
    return r;
  endfunction

  // restoring quotient search, elaboration only
  function automatic longint unsigned quot14(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, t;
    q = 0;
    for (int b = 13; b >= 0; b--) begin
      t = q | (64'd1 << b);
      if (t * den <= num) q = t;
    end
    return q;
  endfunction

  function automatic longint bin_centre(input int i);
    return -64'sd32768 + (longint'(2 * i + 1) * 64'sd65536) / (2 * ACT_TABLE_DEPTH);
  endfunction

  function automatic act_table_t build_sig();
    act_table_t tb;
    longint c;
    longint unsigned a, e, den, s;
    for (int i = 0; i < ACT_TABLE_DEPTH; i++) begin
      c   = bin_centre(i);
      a   = (c < 0) ? longint'(-c) : c;
      e   = exp_neg(a);
      den = Q30_ONE + e;
      s   = quot14((64'd4096 << 30) + (den >> 1), den);
      tb[i] = (c < 0) ? 16'(64'd4096 - s) : 16'(s);
    end
    return tb;
  endfunction

  function automatic act_table_t build_tanh();
    act_table_t tb;
    longint c;
    longint unsigned a, e, den, th;
    for (int i = 0; i < ACT_TABLE_DEPTH; i++) begin
      c   = bin_centre(i);
      a   = (c < 0) ? longint'(-c) : c;
      e   = exp_neg(2 * a);
      den = Q30_ONE + e;
      th  = quot14((Q30_ONE - e) * 64'd4096 + (den >> 1), den);
      tb[i] = (c < 0) ? 16'(64'd0 - th) : 16'(th);
    end
    return tb;
  endfunction

  localparam act_table_t SIG_TABLE  = build_sig();
  localparam act_table_t TANH_TABLE = build_tanh();

endpackage

@@ rtl/neuron_forward_backprop.sv @@
// A forward result is emitted once the last forward word has passed the multiply,
// accumulate, z-sum and activation steps; an output-gradient word, or the last
// hidden word after its hidden sum, goes through the derivative and gradient steps.
// Queued words are taken one at a time; one shared 32x20 multiplier sequences each step.
// Reset clears the 4-word queue, sums, bias, output, delta and gradient;
// weights stay undefined until loaded.
module neuron_forward_backprop import nfb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [15:0] value,
  input  logic signed [15:0] next_gradient,
  input  logic [5:0]         element_index,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] result_value,
  output logic               result_kind,
  output logic               saturated
);

  cfg_t  cfg;
  logic  q_valid, q_pop;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate     <= RATE_RESET;
      cfg.activation_mode   <= MODE_SIGMOID;
      cfg.output_layer_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RATE: cfg.learning_rate     <= cfg_data;
        CFG_MODE: cfg.activation_mode   <= cfg_data[1:0];
        CFG_OLM:  cfg.output_layer_mode <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  nfb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .value         (value),
    .next_gradient (next_gradient),
    .element_index (element_index),
    .last          (last),
    .q_pop         (q_pop),
    .q_valid       (q_valid),
    .q_item        (q_item)
  );

  nfb_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_value (result_value),
    .result_kind  (result_kind),
    .saturated    (saturated)
  );

endmodule

@@ rtl/nfb_front.sv @@
module nfb_front import nfb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic signed [15:0] value,
  input  logic signed [15:0] next_gradient,
  input  logic [5:0]         element_index,
  input  logic               last,
  input  logic               q_pop,
  output logic               q_valid,
  output item_t              q_item
);

  item_t               fifo [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wptr, rptr;
  logic [FQ_CNT_W-1:0] count;
  item_t               item;
  logic [15:0]         idx_ext;
  logic                push;

  always_comb begin
    idx_ext            = 16'(element_index);
    item.op            = action;
    item.value         = value;
    item.next_gradient = next_gradient;
    item.idx           = idx_ext[WADDR_W-1:0];
    item.inrange       = idx_ext < 16'(MAX_INPUTS);
    item.last          = last;
  end

  assign in_ready = count != FQ_CNT_W'(FQ_DEPTH);
  assign push     = in_valid && in_ready;
  assign q_valid  = count != '0;
  assign q_item   = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end

endmodule

@@ rtl/nfb_back.sv @@
module nfb_back import nfb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] result_value,
  output logic               result_kind,
  output logic               saturated
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_MUL   = 10'b0000000010,
    S_ACC   = 10'b0000000100,
    S_HSUM  = 10'b0000001000,
    S_DPROD = 10'b0000010000,
    S_DERIV = 10'b0000100000,
    S_GPROD = 10'b0001000000,
    S_GRAD  = 10'b0010000000,
    S_ZSUM  = 10'b0100000000,
    S_ACT   = 10'b1000000000
  } state_t;

  state_t state;
  item_t  cur;

  logic signed [15:0] wmem [MAX_INPUTS];
  logic signed [15:0] wrd;
  logic signed [51:0] prod;
  logic signed [39:0] sum;
  logic signed [15:0] bias, nout, edelta, egrad, gx, zval;
  logic signed [19:0] deriv;
  logic               clip;

  logic signed [31:0] mul_a;
  logic signed [19:0] mul_b;
  logic signed [51:0] mul_p;
  logic signed [17:0] one_minus;
  logic signed [15:0] err;

  logic signed [39:0] sum_add, z_pre;
  logic signed [63:0] bias_d, w_d, d_sig, d_tanh;
  sat16_t             bias_new, w_new, z_sat, h_sat, g_sat, delta_sat;
  logic [15:0]        z_off;
  logic [31:0]        tix_full;
  logic [31:0]        tix;
  logic [ACT_IDX_W-1:0] tsel;
  logic signed [15:0] act_val;
  logic               can_emit, emit;
  logic               wr_en;
  logic signed [15:0] wr_data;
  logic [15:0]        rate_ext;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign can_emit = !out_valid || out_ready;
  assign emit     = ((state == S_GRAD) || (state == S_ACT)) && can_emit;
  assign err      = cfg.output_layer_mode ? edelta : egrad;
  assign one_minus = 18'sd4096 - 18'(nout);
  assign rate_ext = cfg.learning_rate;

  // single shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MUL: begin
        case (cur.op)
          OP_FWD:  begin mul_a = 32'(cur.value); mul_b = 20'(wrd); end
          OP_HID:  begin mul_a = 32'(cur.value); mul_b = 20'(cur.next_gradient); end
          OP_WUPD: begin mul_a = 32'(cur.value); mul_b = 20'(err); end
          OP_BUPD: begin mul_a = 32'(egrad); mul_b = {4'b0, rate_ext}; end
          default: ;
        endcase
      end
      S_ACC: begin
        mul_a = prod[31:0];
        mul_b = {4'b0, rate_ext};
      end
      S_DPROD: begin
        mul_a = 32'(nout);
        mul_b = (cfg.activation_mode == MODE_TANH) ? 20'(nout) : 20'(one_minus);
      end
      S_GPROD: begin
        mul_a = 32'(gx);
        mul_b = deriv;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    sum_add   = sat40(64'(sum) + 64'(prod));
    bias_d    = rnd_shr(64'(prod), 16);
    bias_new  = sat16(64'(bias) + bias_d);
    w_d       = rnd_shr(64'(prod), 28);
    w_new     = sat16(64'(wrd) + w_d);
    z_pre     = sat40(64'(sum) + (64'(bias) <<< 12));
    z_sat     = sat16(rnd_shr(64'(z_pre), 12));
    h_sat     = sat16(rnd_shr(64'(sum), 12));
    g_sat     = sat16(rnd_shr(64'(prod), 12));
    delta_sat = sat16(64'(cur.value) - 64'(nout));
    d_sig     = rnd_shr(64'(prod), 12);
    d_tanh    = rnd_shr(64'sd16777216 - 64'(prod), 12);
  end

  // table index: ((z + 32768) * depth) >> 16, held inside the table
  always_comb begin
    z_off    = {~zval[15], zval[14:0]};
    tix_full = 32'(z_off) * 32'(ACT_TABLE_DEPTH);
    tix      = tix_full >> 16;
    if (tix >= 32'(ACT_TABLE_DEPTH)) tix = 32'(ACT_TABLE_DEPTH - 1);
    tsel = tix[ACT_IDX_W-1:0];
    unique case (cfg.activation_mode)
      MODE_SIGMOID: act_val = SIG_TABLE[tsel];
      MODE_RELU:    act_val = (zval > 16'sd0) ? zval : 16'sd0;
      MODE_TANH:    act_val = TANH_TABLE[tsel];
      default:      act_val = 16'sd0;
    endcase
  end

  // loads write in the multiply step, weight updates on their way out of S_ZSUM
  always_comb begin
    wr_en   = ((state == S_MUL) && (cur.op == OP_LDW) && cur.inrange) ||
              ((state == S_ZSUM) && (cur.op == OP_WUPD));
    wr_data = (state == S_MUL) ? cur.value : w_new.val;
  end

  always_ff @(posedge clk) begin
    if (wr_en) wmem[cur.idx] <= wr_data;
    if (q_pop) wrd <= wmem[q_item.idx];
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      sum    <= '0;
      bias   <= '0;
      nout   <= '0;
      edelta <= '0;
      egrad  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_MUL;
            clip  <= 1'b0;
          end
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_IDLE;
          case (cur.op)
            OP_FWD, OP_HID, OP_BUPD: state <= S_ACC;
            OP_WUPD: if (cur.inrange) state <= S_ACC;
            OP_OUTG: begin
              edelta <= delta_sat.val;
              gx     <= delta_sat.val;
              clip   <= delta_sat.clip;
              state  <= S_DPROD;
            end
            OP_LDB:  bias <= cur.value;
            default: ;
          endcase
        end
        S_ACC: begin
          state <= S_IDLE;
          case (cur.op)
            OP_FWD: begin
              if (cur.inrange) sum <= sum_add;
              if (cur.last) state <= S_ZSUM;
            end
            OP_HID: begin
              sum <= sum_add;
              if (cur.last) state <= S_HSUM;
            end
            OP_WUPD: begin
              prod  <= mul_p;
              state <= S_ZSUM;
            end
            OP_BUPD: bias <= bias_new.val;
            default: ;
          endcase
        end
        S_HSUM: begin
          gx    <= h_sat.val;
          clip  <= h_sat.clip;
          sum   <= '0;
          state <= S_DPROD;
        end
        S_DPROD: begin
          prod  <= mul_p;
          state <= S_DERIV;
        end
        S_DERIV: begin
          unique case (cfg.activation_mode)
            MODE_SIGMOID: deriv <= d_sig[19:0];
            MODE_RELU:    deriv <= (nout > 16'sd0) ? 20'sd4096 : 20'sd0;
            MODE_TANH:    deriv <= d_tanh[19:0];
            default:      deriv <= 20'sd0;
          endcase
          state <= S_GPROD;
        end
        S_GPROD: begin
          prod  <= mul_p;
          state <= S_GRAD;
        end
        S_GRAD: begin
          if (can_emit) begin
            egrad <= g_sat.val;
            state <= S_IDLE;
          end
        end
        S_ZSUM: begin
          // weight updates pass through here to write back the stored word
          if (cur.op == OP_WUPD) begin
            state <= S_IDLE;
          end else begin
            zval  <= z_sat.val;
            clip  <= z_sat.clip;
            sum   <= '0;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (can_emit) begin
            nout  <= act_val;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (state == S_ACT) begin
        result_value <= act_val;
        result_kind  <= 1'b0;
        saturated    <= clip;
      end else begin
        result_value <= g_sat.val;
        result_kind  <= 1'b1;
        saturated    <= clip | g_sat.clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule
